// ===== design/nebe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nebe_pkg
// Types and constants shared by the note event byte encoder modules.
// ----------------------------------------------------------------------------
package nebe_pkg;

	localparam int NOTES  = 128;
	localparam int NOTE_W = 7;

	localparam logic [7:0] DELAY_BYTE = 8'h7f;
	localparam logic [7:0] PACK_BASE  = 8'h80;
	localparam logic [7:0] NOTE_ON    = 8'hb0;
	localparam logic [7:0] NOTE_OFF   = 8'hc0;
	localparam logic [6:0] PACK_LO    = 7'h20;
	localparam logic [6:0] PACK_HI    = 7'h60;
	localparam int         DUR_LIMIT  = 64;
	localparam int         DELAY_UNIT = 127;

	typedef enum logic [1:0] {
		K_PACKED,
		K_ONOFF,
		K_ON,
		K_OFF
	} kind_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_FULL,
		S_REM,
		S_CMD
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic look;
		logic full_emit;
		logic rem_emit;
		logic cmd_emit;
	} ctl_t;

	typedef struct packed {
		logic ign;
		logic drop;
		logic more_full;
		logic rem_zero;
		logic cmd_last;
		logic clr_done;
		logic slot_free;
	} sts_t;

endpackage

// ===== design/nebe_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nebe_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module nebe_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/nebe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nebe_ctrl
// Sequencer: flag clear pass, event lookup, delay run, remainder, command.
// ----------------------------------------------------------------------------
module nebe_ctrl import nebe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output ctl_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (!sts.ign) begin
						state_d = S_LOOK;
					end
				end
			end
			S_LOOK: begin
				if (sts.drop) begin
					state_d = S_IDLE;
				end else begin
					cmd.look = 1'b1;
					state_d  = S_FULL;
				end
			end
			S_FULL: begin
				if (sts.more_full) begin
					cmd.full_emit = sts.slot_free;
				end else begin
					state_d = S_REM;
				end
			end
			S_REM: begin
				if (sts.rem_zero) begin
					state_d = S_CMD;
				end else if (sts.slot_free) begin
					cmd.rem_emit = 1'b1;
					state_d      = S_CMD;
				end
			end
			S_CMD: begin
				if (sts.slot_free) begin
					cmd.cmd_emit = 1'b1;
					if (sts.cmd_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.full_emit || cmd.rem_emit || cmd.cmd_emit) |-> sts.slot_free)
		else $error("byte emitted while output register busy");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command");

	a_look_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOK) |-> $past(state_q) == S_IDLE)
		else $error("lookup entered without an accepted transaction");

endmodule

// ===== design/nebe_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nebe_dp
// Datapath: event registers, output clock, pending note-off flags,
// delay run counters and the output byte register.
// ----------------------------------------------------------------------------
module nebe_dp import nebe_pkg::*; #(
	parameter int CHANNELS        = 16,
	parameter int TIME_BITS       = 24,
	parameter int MAX_FULL_DELAYS = 58
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctl_t                 cmd,
	output sts_t                 sts,
	input  logic                 op,
	input  logic [TIME_BITS-1:0] event_time,
	input  logic [4:0]           channel,
	input  logic [6:0]           note,
	input  logic [6:0]           velocity,
	input  logic                 has_partner,
	input  logic [TIME_BITS-1:0] partner_time,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_byte,
	output logic                 last,
	output logic                 delay_overflow
);

	localparam int DEPTH = CHANNELS * NOTES;
	localparam int AW    = $clog2(DEPTH);
	localparam int ND    = (TIME_BITS + 6) / 7;
	localparam int PW    = ND * 7;
	localparam logic [32:0] CAP_TICKS = 33'(DELAY_UNIT * (MAX_FULL_DELAYS + 1));

	function automatic logic [6:0] mod127(input logic [TIME_BITS-1:0] v);
		logic [PW-1:0] p;
		logic [9:0]    s;
		logic [7:0]    f;
		p = PW'(v);
		s = '0;
		for (int i = 0; i < ND; i++) begin
			s = s + 10'(p[i*7 +: 7]);
		end
		f = 8'(s[6:0]) + 8'(s[9:7]);
		if (f >= 8'(DELAY_UNIT)) begin
			f = f - 8'(DELAY_UNIT);
		end
		return f[6:0];
	endfunction

	// event registers
	logic                 op_q;
	logic [TIME_BITS-1:0] t_q;
	logic [4:0]           ch_q;
	logic [6:0]           note_q;
	logic [6:0]           vel_q;
	logic                 hp_q;
	logic [TIME_BITS-1:0] delta_q;
	logic                 gt_q;
	logic [TIME_BITS-1:0] dur_q;
	logic                 pgt_q;
	logic [AW-1:0]        addr_q;

	// per item working state
	logic [TIME_BITS-1:0] clock_q;
	logic [TIME_BITS-1:0] remaining_q;
	logic [5:0]           full_cnt_q;
	logic [6:0]           rem_q;
	logic                 ovf_q;
	kind_t                kind_q;
	logic [2:0]           idx_q;
	logic [5:0]           dur6_q;
	logic [AW-1:0]        clr_addr_q;

	// output register
	logic                 ovalid_q;
	logic [7:0]           obyte_q;
	logic                 olast_q;
	logic                 oovf_q;

	logic                 flag_rd;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic                 ram_wdata;
	logic [TIME_BITS-1:0] ticks;
	logic                 capped;
	logic                 dur_pos;
	logic                 dur_small;
	kind_t                kind_d;
	logic [6:0]           note_off;
	logic [7:0]           cmd_byte;
	logic [2:0]           cmd_len;
	logic                 any_emit;

	nebe_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_flags (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.load),
		.raddr (AW'({channel, note})),
		.rdata (flag_rd)
	);

	assign ticks     = gt_q ? delta_q : '0;
	assign capped    = gt_q && (33'(delta_q) >= CAP_TICKS);
	assign dur_pos   = hp_q && pgt_q;
	assign dur_small = !dur_pos || (dur_q < TIME_BITS'(DUR_LIMIT));

	always_comb begin
		if (op_q) begin
			kind_d = K_OFF;
		end else if (dur_small && note_q >= PACK_LO && note_q < PACK_HI) begin
			kind_d = K_PACKED;
		end else if (!hp_q) begin
			kind_d = K_ONOFF;
		end else begin
			kind_d = K_ON;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = 1'b0;
		if (cmd.clr_step) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
		end else if (cmd.look) begin
			ram_we    = op_q || (kind_d == K_ON);
			ram_wdata = !op_q;
		end
	end

	assign note_off = note_q - PACK_LO;

	always_comb begin
		cmd_byte = '0;
		cmd_len  = 3'd3;
		case (kind_q)
			K_PACKED: begin
				cmd_len = 3'd3;
				case (idx_q)
					3'd0:    cmd_byte = PACK_BASE | {3'b000, vel_q[6:2]};
					3'd1:    cmd_byte = {note_off[5:0], dur6_q[5:4]};
					default: cmd_byte = {dur6_q[3:0], ch_q[3:0]};
				endcase
			end
			K_ONOFF: begin
				cmd_len = 3'd5;
				case (idx_q)
					3'd0:    cmd_byte = NOTE_ON | {4'b0000, ch_q[3:0]};
					3'd1:    cmd_byte = {1'b0, note_q};
					3'd2:    cmd_byte = {1'b0, vel_q};
					3'd3:    cmd_byte = NOTE_OFF | {4'b0000, ch_q[3:0]};
					default: cmd_byte = {1'b0, note_q};
				endcase
			end
			K_ON: begin
				cmd_len = 3'd3;
				case (idx_q)
					3'd0:    cmd_byte = NOTE_ON | {4'b0000, ch_q[3:0]};
					3'd1:    cmd_byte = {1'b0, note_q};
					default: cmd_byte = {1'b0, vel_q};
				endcase
			end
			K_OFF: begin
				cmd_len = 3'd2;
				case (idx_q)
					3'd0:    cmd_byte = NOTE_OFF | {4'b0000, ch_q[3:0]};
					default: cmd_byte = {1'b0, note_q};
				endcase
			end
			default: begin
				cmd_len  = 3'd2;
				cmd_byte = '0;
			end
		endcase
	end

	assign any_emit = cmd.full_emit || cmd.rem_emit || cmd.cmd_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q     <= '0;
			clr_addr_q  <= '0;
			remaining_q <= '0;
			full_cnt_q  <= '0;
			idx_q       <= '0;
			kind_q      <= K_OFF;
			ovalid_q    <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (cmd.look) begin
				clock_q     <= t_q;
				remaining_q <= ticks;
				full_cnt_q  <= '0;
				idx_q       <= '0;
				kind_q      <= kind_d;
			end
			if (cmd.full_emit) begin
				remaining_q <= remaining_q - TIME_BITS'(DELAY_UNIT);
				full_cnt_q  <= full_cnt_q + 6'd1;
			end
			if (cmd.cmd_emit) begin
				idx_q <= idx_q + 3'd1;
			end
			if (any_emit) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			t_q     <= event_time;
			ch_q    <= channel;
			note_q  <= note;
			vel_q   <= velocity;
			hp_q    <= has_partner;
			delta_q <= event_time - clock_q;
			gt_q    <= event_time > clock_q;
			dur_q   <= partner_time - event_time;
			pgt_q   <= partner_time > event_time;
			addr_q  <= AW'({channel, note});
		end
		if (cmd.look) begin
			rem_q  <= mod127(ticks);
			ovf_q  <= capped;
			dur6_q <= dur_pos ? dur_q[5:0] : 6'd0;
		end
		if (cmd.full_emit) begin
			obyte_q <= DELAY_BYTE;
			olast_q <= 1'b0;
			oovf_q  <= ovf_q;
		end else if (cmd.rem_emit) begin
			obyte_q <= {1'b0, rem_q};
			olast_q <= 1'b0;
			oovf_q  <= ovf_q;
		end else if (cmd.cmd_emit) begin
			obyte_q <= cmd_byte;
			olast_q <= (idx_q == cmd_len - 3'd1);
			oovf_q  <= ovf_q;
		end
	end

	assign sts.ign       = channel >= 5'(CHANNELS);
	assign sts.drop      = op_q && !flag_rd;
	assign sts.more_full = (remaining_q >= TIME_BITS'(DELAY_UNIT))
		&& (full_cnt_q < 6'(MAX_FULL_DELAYS));
	assign sts.rem_zero  = (rem_q == 7'd0);
	assign sts.cmd_last  = (idx_q == cmd_len - 3'd1);
	assign sts.clr_done  = (clr_addr_q == AW'(DEPTH - 1));
	assign sts.slot_free = !ovalid_q || !out_stall;

	assign out_valid      = ovalid_q;
	assign out_byte       = obyte_q;
	assign last           = olast_q;
	assign delay_overflow = oovf_q;

	a_full_cap: assert property (@(posedge clk) disable iff (!arst_n)
		full_cnt_q <= 6'(MAX_FULL_DELAYS))
		else $error("delay run exceeded its cap");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.look |=> rem_q != 7'h7f)
		else $error("delay remainder out of range");

endmodule

// ===== design/note_event_byte_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_event_byte_encoder
// Turns timed note events into a compact song byte stream.
//
// Input channel: in_valid / in_stall with one note event per transaction.
// Output channel: out_valid / out_stall with one stream byte per transaction;
// last marks the final byte of an event, delay_overflow marks every byte of
// an event whose run of full delay bytes was capped.
// After acceptance an event passes through lookup, a run of F full delay
// bytes, a remainder delay byte when the remainder is nonzero and C command
// bytes (2, 3 or 5); the remainder has its own sequencer state, visited even
// when no remainder byte is sent. A dropped note-off and an ignored channel send nothing.
// Bytes leave through a single output register; the first byte is a full
// delay byte when there are any, otherwise the remainder byte, otherwise the
// first command byte. A new event is accepted only after the sequencer has
// issued every byte of the current one. After reset the pending note-off flag
// memory is cleared, one entry a cycle, all CHANNELS * 128 entries, while
// in_stall stays high; the output clock resets to zero. A stalled receiver
// holds the current byte and pauses the sequencer.
// ----------------------------------------------------------------------------
module note_event_byte_encoder import nebe_pkg::*; #(
	parameter int CHANNELS        = 16,
	parameter int TIME_BITS       = 24,
	parameter int MAX_FULL_DELAYS = 58
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 op,
	input  logic [TIME_BITS-1:0] event_time,
	input  logic [4:0]           channel,
	input  logic [6:0]           note,
	input  logic [6:0]           velocity,
	input  logic                 has_partner,
	input  logic [TIME_BITS-1:0] partner_time,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_byte,
	output logic                 last,
	output logic                 delay_overflow
);

	ctl_t cmd;
	sts_t sts;

	nebe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	nebe_dp #(
		.CHANNELS        (CHANNELS),
		.TIME_BITS       (TIME_BITS),
		.MAX_FULL_DELAYS (MAX_FULL_DELAYS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.op             (op),
		.event_time     (event_time),
		.channel        (channel),
		.note           (note),
		.velocity       (velocity),
		.has_partner    (has_partner),
		.partner_time   (partner_time),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.last           (last),
		.delay_overflow (delay_overflow)
	);

endmodule
